@@ rtl/adsc_pkg.sv @@
// ----------------------------------------------------------------------------
// adsc_pkg
// Shared types, constants and the palette for the attribute display
// scanline generator.
// ----------------------------------------------------------------------------
package adsc_pkg;

  localparam int unsigned TOP_BORDER_LINES    = 48;
  localparam int unsigned BOTTOM_BORDER_LINES = 56;
  localparam int unsigned SIDE_BORDER_PIXELS  = 32;

  localparam int unsigned DISPLAY_COLS = 256;
  localparam int unsigned DISPLAY_ROWS = 192;
  localparam int unsigned FRAME_LINES  =
    TOP_BORDER_LINES + DISPLAY_ROWS + BOTTOM_BORDER_LINES;

  localparam int unsigned BITMAP_BYTES = 6144;
  localparam int unsigned ATTR_BYTES   = 768;
  localparam int unsigned STORE_BYTES  = BITMAP_BYTES + ATTR_BYTES;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned OFFSET_W = 13;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned LINE_W   = 9;
  localparam int unsigned GROUP_W  = 6;
  localparam int unsigned COLOR_W  = 4;
  localparam int unsigned RGB_W    = 24;
  localparam int unsigned BORDER_W = 3;

  localparam int unsigned BITMAP_AW = $clog2(BITMAP_BYTES);
  localparam int unsigned ATTR_AW   = $clog2(ATTR_BYTES);

  localparam logic [BORDER_W-1:0] BORDER_RESET = 3'd7;
  localparam logic [7:0]          LEVEL_BASE   = 8'hD8;
  localparam logic [7:0]          LEVEL_BRIGHT = 8'hFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_STORE  = 2'd0,
    KIND_PORT   = 2'd1,
    KIND_RENDER = 2'd2
  } kind_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RENDER
  } seq_state_t;

  // One pixel request from the sequencer to the pixel stage.
  typedef struct packed {
    logic                valid;
    logic                disp;
    logic [2:0]          bitpos;
    logic                phase;
    logic [BORDER_W-1:0] border;
    logic                last;
  } pix_issue_t;

  function automatic logic [RGB_W-1:0] palette_rgb(input logic [COLOR_W-1:0] idx);
    logic [7:0] lvl;
    lvl = idx[3] ? LEVEL_BRIGHT : LEVEL_BASE;
    palette_rgb = {idx[1] ? lvl : 8'h00, idx[2] ? lvl : 8'h00, idx[0] ? lvl : 8'h00};
  endfunction

endpackage

@@ rtl/adsc_if.sv @@
// ----------------------------------------------------------------------------
// adsc_if
// Request and pixel channels of the attribute display scanline generator.
// ----------------------------------------------------------------------------
interface adsc_in_if import adsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [OFFSET_W-1:0] store_offset;
  logic [DATA_W-1:0]   data;
  logic [PORT_W-1:0]   port_addr;
  logic [LINE_W-1:0]   line;
  logic [GROUP_W-1:0]  group;
  logic                flash_phase;

  modport source (output valid, kind, store_offset, data, port_addr, line, group,
                  flash_phase, input ready);
  modport sink (input valid, kind, store_offset, data, port_addr, line, group,
                flash_phase, output ready);
endinterface

interface adsc_out_if import adsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pal_index;
  logic [RGB_W-1:0]   pixel_rgb;
  logic               last;

  modport source (output valid, pal_index, pixel_rgb, last, input ready);
  modport sink (input valid, pal_index, pixel_rgb, last, output ready);
endinterface

@@ rtl/adsc_ram.sv @@
// ----------------------------------------------------------------------------
// adsc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module adsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/adsc_seq.sv @@
// ----------------------------------------------------------------------------
// adsc_seq
// Request decoder and pixel sequencer: store writes, border port, and
// one bitmap/attribute fetch per pixel of a render request.
// ----------------------------------------------------------------------------
module adsc_seq import adsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  adsc_in_if.sink              in_chan,
  input  logic                 take,
  output pix_issue_t           issue,
  output logic                 bmp_we,
  output logic [BITMAP_AW-1:0] bmp_waddr,
  output logic                 atr_we,
  output logic [ATTR_AW-1:0]   atr_waddr,
  output logic [DATA_W-1:0]    wdata,
  output logic [BITMAP_AW-1:0] bmp_raddr,
  output logic [ATTR_AW-1:0]   atr_raddr
);

  localparam logic [LINE_W:0] ROW_FIRST = (LINE_W+1)'(TOP_BORDER_LINES);
  localparam logic [LINE_W:0] ROW_END   = (LINE_W+1)'(TOP_BORDER_LINES + DISPLAY_ROWS);
  localparam logic [LINE_W:0] COL_FIRST = (LINE_W+1)'(SIDE_BORDER_PIXELS);
  localparam logic [LINE_W:0] COL_END   = (LINE_W+1)'(SIDE_BORDER_PIXELS + DISPLAY_COLS);
  localparam logic [OFFSET_W-1:0] BMP_LIMIT   = OFFSET_W'(BITMAP_BYTES);
  localparam logic [OFFSET_W-1:0] STORE_LIMIT = OFFSET_W'(STORE_BYTES);

  seq_state_t          state_r, state_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [LINE_W-1:0]   line_r;
  logic [GROUP_W-1:0]  group_r;
  logic                phase_r;
  logic [BORDER_W-1:0] border_r, border_nxt;

  logic                accept;
  logic                is_render;
  logic [LINE_W:0]     line_ext;
  logic [LINE_W:0]     x_ext;
  logic [LINE_W:0]     row_diff;
  logic [LINE_W:0]     col_diff;
  logic [7:0]          row;
  logic [7:0]          col;
  logic                in_rows;
  logic                in_cols;
  logic [OFFSET_W-1:0] atr_off;

  assign accept    = in_chan.valid && in_chan.ready;
  assign is_render = kind_t'(in_chan.kind) == KIND_RENDER;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (accept && is_render) begin
          state_nxt = SEQ_RENDER;
        end
      end
      SEQ_RENDER: begin
        if (take && cnt_r == 3'd7) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    border_nxt = border_r;
    if (accept && is_render) begin
      cnt_nxt = 3'd0;
    end else if (state_r == SEQ_RENDER && take) begin
      cnt_nxt = cnt_r + 3'd1;
    end
    if (accept && kind_t'(in_chan.kind) == KIND_PORT && !in_chan.port_addr[0]) begin
      border_nxt = in_chan.data[BORDER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SEQ_IDLE;
      cnt_r    <= 3'd0;
      border_r <= BORDER_RESET;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      border_r <= border_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_render) begin
      line_r  <= in_chan.line;
      group_r <= in_chan.group;
      phase_r <= in_chan.flash_phase;
    end
  end

  // Pixel position and display addressing for the current pixel.
  always_comb begin
    line_ext  = {1'b0, line_r};
    x_ext     = {1'b0, group_r, cnt_r};
    row_diff  = line_ext - ROW_FIRST;
    col_diff  = x_ext - COL_FIRST;
    row       = row_diff[7:0];
    col       = col_diff[7:0];
    in_rows   = line_ext >= ROW_FIRST && line_ext < ROW_END;
    in_cols   = x_ext >= COL_FIRST && x_ext < COL_END;
    bmp_raddr = {row[7:6], row[2:0], row[5:3], col[7:3]};
    atr_raddr = {row[7:3], col[7:3]};
  end

  always_comb begin
    in_chan.ready = state_r == SEQ_IDLE;

    issue.valid  = state_r == SEQ_RENDER;
    issue.disp   = in_rows && in_cols;
    issue.bitpos = col[2:0];
    issue.phase  = phase_r;
    issue.border = border_r;
    issue.last   = cnt_r == 3'd7;

    atr_off   = in_chan.store_offset - BMP_LIMIT;
    wdata     = in_chan.data;
    bmp_waddr = in_chan.store_offset;
    atr_waddr = atr_off[ATTR_AW-1:0];
    bmp_we    = accept && kind_t'(in_chan.kind) == KIND_STORE &&
                in_chan.store_offset < BMP_LIMIT;
    atr_we    = accept && kind_t'(in_chan.kind) == KIND_STORE &&
                in_chan.store_offset >= BMP_LIMIT && in_chan.store_offset < STORE_LIMIT;
  end

endmodule

@@ rtl/adsc_pix.sv @@
// ----------------------------------------------------------------------------
// adsc_pix
// Pixel stage: waits for fetched bitmap and attribute bytes, resolves
// ink/paper/flash or border, and holds the pixel in the output register.
// ----------------------------------------------------------------------------
module adsc_pix import adsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pix_issue_t  issue,
  output logic        take,
  input  logic [7:0]  bits_rd,
  input  logic [7:0]  attr_rd,
  adsc_out_if.source  out_chan
);

  pix_issue_t         s1_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] color_r;
  logic [RGB_W-1:0]   rgb_r;
  logic               last_r;

  logic               adv;
  logic               set;
  logic [COLOR_W-1:0] ink;
  logic [COLOR_W-1:0] paper;
  logic [COLOR_W-1:0] idx;
  logic [2:0]         sel;

  assign adv  = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign take = !s1_valid_r || adv;

  always_comb begin
    sel   = 3'd7 - s1_r.bitpos;
    ink   = {attr_rd[6], attr_rd[2:0]};
    paper = attr_rd[6:3];
    set   = bits_rd[sel] ^ (attr_rd[7] && s1_r.phase);
    if (s1_r.disp) begin
      idx = set ? ink : paper;
    end else begin
      idx = {1'b0, s1_r.border};
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (take) begin
      s1_valid_nxt = issue.valid;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && issue.valid) begin
      s1_r <= issue;
    end
    if (adv) begin
      color_r <= idx;
      rgb_r   <= palette_rgb(idx);
      last_r  <= s1_r.last;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pal_index = color_r;
  assign out_chan.pixel_rgb = rgb_r;
  assign out_chan.last      = last_r;

endmodule

@@ rtl/attribute_display_scanline_top.sv @@
// ----------------------------------------------------------------------------
// attribute_display_scanline_top
// Attribute display scanline generator: bitmap/attribute display store,
// border port and eight-pixel render requests.
// ----------------------------------------------------------------------------
// Store and port writes are accepted while idle. A render request is
// accepted, then its eight pixels are fetched one at a time, as each
// display memory has a single read port (bitmap and attribute bytes are
// fetched once per pixel). Pixels leave one per cycle while the pixel
// channel is not stalled, from an output register behind the registered
// memory read. The display store is not cleared at reset; rendering bytes
// that were never written gives unspecified colors.
module attribute_display_scanline_top import adsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  adsc_in_if.sink   in_chan,
  adsc_out_if.source out_chan
);

  pix_issue_t           issue;
  logic                 take;
  logic                 rd_en;
  logic                 bmp_we;
  logic [BITMAP_AW-1:0] bmp_waddr;
  logic                 atr_we;
  logic [ATTR_AW-1:0]   atr_waddr;
  logic [DATA_W-1:0]    wdata;
  logic [BITMAP_AW-1:0] bmp_raddr;
  logic [ATTR_AW-1:0]   atr_raddr;
  logic [7:0]           bits_rd;
  logic [7:0]           attr_rd;

  assign rd_en = issue.valid && take;

  adsc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .take      (take),
    .issue     (issue),
    .bmp_we    (bmp_we),
    .bmp_waddr (bmp_waddr),
    .atr_we    (atr_we),
    .atr_waddr (atr_waddr),
    .wdata     (wdata),
    .bmp_raddr (bmp_raddr),
    .atr_raddr (atr_raddr)
  );

  adsc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BITMAP_BYTES)
  ) u_bitmap_ram (
    .clk     (clk),
    .wr_en   (bmp_we),
    .wr_addr (bmp_waddr),
    .wr_data (wdata),
    .rd_en   (rd_en),
    .rd_addr (bmp_raddr),
    .rd_data (bits_rd)
  );

  adsc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ATTR_BYTES)
  ) u_attr_ram (
    .clk     (clk),
    .wr_en   (atr_we),
    .wr_addr (atr_waddr),
    .wr_data (wdata),
    .rd_en   (rd_en),
    .rd_addr (atr_raddr),
    .rd_data (attr_rd)
  );

  adsc_pix u_pix (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (issue),
    .take     (take),
    .bits_rd  (bits_rd),
    .attr_rd  (attr_rd),
    .out_chan (out_chan)
  );

endmodule
